// ----- rtl/ffpa_pkg.sv -----
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared word types and codes for the first-fit partition allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  // Fixed field widths of the input and result words
  localparam int ACT_W   = 2;
  localparam int IDX_F_W = 6;
  localparam int REQ_F_W = 16;
  localparam int OWN_F_W = 8;
  localparam int ST_W    = 2;
  localparam int TOTAL_W = 22;
  localparam int CFG_W   = 7;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = '1;
  localparam logic [CFG_W-1:0]   CFG_RST_VAL = 7'd64;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_LOAD    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NO_FIT    = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD_INDEX = 2'd2;

  typedef struct packed {
    logic [ACT_W-1:0]   action;
    logic [IDX_F_W-1:0] partition_index;
    logic               use_preferred;
    logic [REQ_F_W-1:0] request_size;
    logic [OWN_F_W-1:0] owner_id;
  } in_word_t;

  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [IDX_F_W-1:0] partition_index_out;
    logic [REQ_F_W-1:0] fragment;
    logic [OWN_F_W-1:0] owner_out;
    logic [TOTAL_W-1:0] total_internal;
    logic [TOTAL_W-1:0] total_external;
  } out_word_t;

endpackage

// ----- rtl/first_fit_partition_allocator.sv -----
// Flow: an accepted word passes through the sweep and the finish state before its
//   result is registered; an allocate with a usable preferred partition index first
//   reads that entry early. A new word is taken only in idle, once the last result
//   is registered; the sweep reads and writes back one partition memory entry per
//   cycle for every word. Reset: synchronous; a clearing pass zeroes the memory,
//   with in_ready low. The register cfg_r (partitions in use) resets to 64.
// ----------------------------------------------------------------------------
// first_fit_partition_allocator
// Fixed-partition allocator: table of sizes, busy marks, owners and fragments
// in one synchronous memory, swept once per word to apply the action and
// rebuild the fragmentation totals.
// ----------------------------------------------------------------------------
module first_fit_partition_allocator
  import ffpa_pkg::*;
#(
  parameter int PARTITIONS = 64,
  parameter int SIZE_BITS  = 16,
  parameter int OWNER_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(PARTITIONS);
  localparam int NW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int ACC_A = SIZE_BITS + IDX_W + 1;
  localparam int ACC_W = (ACC_A > TOTAL_W + 1) ? ACC_A : TOTAL_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PARTITIONS - 1);

  // One memory entry per partition
  typedef struct packed {
    logic                  busy;
    logic [OWNER_BITS-1:0] owner;
    logic [SIZE_BITS-1:0]  frag;
    logic [SIZE_BITS-1:0]  size;
  } ent_t;

  // Sequencer states
  localparam logic [2:0] S_INIT   = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_PREF   = 3'd2;
  localparam logic [2:0] S_SCAN   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]            state_r, state_nxt;
  logic [CFG_W-1:0]      cfg_r;
  in_word_t              item_r;
  logic [SIZE_BITS-1:0]  req_r;
  logic [OWNER_BITS-1:0] own_r;
  logic [IDX_W-1:0]      init_cnt_r;
  logic [IDX_W-1:0]      issue_cnt_r;
  logic                  issue_done_r;
  logic                  proc_vld_r;
  logic [IDX_W-1:0]      proc_idx_r;
  logic                  pref_hit_r;
  logic                  found_r;
  logic                  ok_r;
  logic [IDX_W-1:0]      pos_r;
  logic [SIZE_BITS-1:0]  frag_r;
  logic [OWNER_BITS-1:0] owner_r;
  logic [ACC_W-1:0]      int_acc_r, ext_acc_r;
  logic                  out_valid_r;
  out_word_t             out_data_r;

  // Memory and its ports
  ent_t                  mem [PARTITIONS];
  ent_t                  rd_data_r;
  logic                  rd_en, wr_en;
  logic [IDX_W-1:0]      rd_addr, wr_addr;
  ent_t                  wr_data;

  logic [NW-1:0]         n_use;
  logic                  in_acc;
  logic                  pref_try;
  logic                  in_use, hit, take, rel_hit;
  ent_t                  new_ent;
  logic [TOTAL_W-1:0]    tot_int, tot_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Partitions in use, clamped to the table
  assign n_use = (NW'(cfg_r) > NW'(PARTITIONS)) ? NW'(PARTITIONS) : NW'(cfg_r);

  assign pref_try = (in_data.action == ACT_ALLOC) && in_data.use_preferred &&
                    (NW'(in_data.partition_index) < n_use);

  // Memory read/write, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_cnt_r;
    if (state_r == S_IDLE && in_acc && pref_try) begin
      rd_en   = 1'b1;
      rd_addr = IDX_W'(in_data.partition_index);
    end else if (state_r == S_SCAN && !issue_done_r) begin
      rd_en = 1'b1;
    end
  end

  // Post-action view of the entry coming out of the memory
  always_comb begin
    in_use  = NW'(proc_idx_r) < n_use;
    hit     = NW'(proc_idx_r) == NW'(item_r.partition_index);
    take    = 1'b0;
    rel_hit = 1'b0;
    new_ent = rd_data_r;
    case (item_r.action)
      ACT_LOAD: begin
        if (hit) begin
          new_ent.size = req_r;
        end
      end
      ACT_ALLOC: begin
        take = pref_hit_r ? hit
                          : (!found_r && in_use && !rd_data_r.busy && rd_data_r.size >= req_r);
        if (take) begin
          new_ent.busy  = 1'b1;
          new_ent.owner = own_r;
          new_ent.frag  = rd_data_r.size - req_r;
        end
      end
      ACT_RELEASE: begin
        rel_hit = hit && rd_data_r.busy;
        if (rel_hit) begin
          new_ent.busy  = 1'b0;
          new_ent.owner = '0;
          new_ent.frag  = '0;
        end
      end
      default: begin
        new_ent.busy  = 1'b0;
        new_ent.owner = '0;
        new_ent.frag  = '0;
      end
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = proc_idx_r;
    wr_data = new_ent;
    if (state_r == S_INIT) begin
      wr_en   = 1'b1;
      wr_addr = init_cnt_r;
      wr_data = '0;
    end else if (state_r == S_SCAN && proc_vld_r) begin
      wr_en = 1'b1;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:   if (init_cnt_r == LAST_IDX) state_nxt = S_IDLE;
      S_IDLE:   if (in_acc) state_nxt = pref_try ? S_PREF : S_SCAN;
      S_PREF:   state_nxt = S_SCAN;
      S_SCAN:   if (proc_vld_r && proc_idx_r == LAST_IDX) state_nxt = S_FINISH;
      S_FINISH: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_INIT;
    endcase
  end

  // Saturated totals
  assign tot_int = (int_acc_r > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(int_acc_r);
  assign tot_ext = (ext_acc_r > ACC_W'(TOTAL_MAX)) ? TOTAL_MAX : TOTAL_W'(ext_acc_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      cfg_r        <= CFG_RST_VAL;
      init_cnt_r   <= '0;
      issue_cnt_r  <= '0;
      issue_done_r <= 1'b0;
      proc_vld_r   <= 1'b0;
      pref_hit_r   <= 1'b0;
      found_r      <= 1'b0;
      ok_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end
      if (state_r == S_INIT) begin
        init_cnt_r <= init_cnt_r + 1'b1;
      end
      if (in_acc) begin
        issue_cnt_r  <= '0;
        issue_done_r <= 1'b0;
        pref_hit_r   <= 1'b0;
        found_r      <= 1'b0;
        ok_r         <= 1'b0;
      end
      // preferred partition check on the early read
      if (state_r == S_PREF) begin
        if (!rd_data_r.busy && rd_data_r.size >= req_r) begin
          pref_hit_r <= 1'b1;
          found_r    <= 1'b1;
        end
      end
      proc_vld_r <= (state_r == S_SCAN) && !issue_done_r;
      if (state_r == S_SCAN && !issue_done_r) begin
        issue_cnt_r <= issue_cnt_r + 1'b1;
        if (issue_cnt_r == LAST_IDX) begin
          issue_done_r <= 1'b1;
        end
      end
      if (state_r == S_SCAN && proc_vld_r) begin
        if (take) begin
          found_r <= 1'b1;
        end
        if (take || rel_hit || (item_r.action == ACT_LOAD && hit)) begin
          ok_r <= 1'b1;
        end
      end
      // result register
      if (state_r == S_FINISH && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r    <= in_data;
      req_r     <= SIZE_BITS'(in_data.request_size);
      own_r     <= OWNER_BITS'(in_data.owner_id);
      pos_r     <= '0;
      frag_r    <= '0;
      owner_r   <= '0;
      int_acc_r <= '0;
      ext_acc_r <= '0;
    end
    proc_idx_r <= issue_cnt_r;
    if (state_r == S_SCAN && proc_vld_r) begin
      if (take) begin
        pos_r  <= proc_idx_r;
        frag_r <= new_ent.frag;
      end
      if (rel_hit) begin
        owner_r <= rd_data_r.owner;
      end
      if (new_ent.busy) begin
        int_acc_r <= int_acc_r + ACC_W'(new_ent.frag);
      end else if (in_use) begin
        ext_acc_r <= ext_acc_r + ACC_W'(new_ent.size);
      end
    end
    if (state_r == S_FINISH && (!out_valid_r || out_ready)) begin
      out_data_r.total_internal      <= tot_int;
      out_data_r.total_external      <= tot_ext;
      out_data_r.status              <= ST_OK;
      out_data_r.partition_index_out <= '0;
      out_data_r.fragment            <= '0;
      out_data_r.owner_out           <= '0;
      case (item_r.action)
        ACT_LOAD: begin
          if (ok_r) begin
            out_data_r.partition_index_out <= item_r.partition_index;
          end else begin
            out_data_r.status <= ST_BAD_INDEX;
          end
        end
        ACT_ALLOC: begin
          if (found_r) begin
            out_data_r.partition_index_out <= IDX_F_W'(pos_r);
            out_data_r.fragment            <= REQ_F_W'(frag_r);
          end else begin
            out_data_r.status <= ST_NO_FIT;
          end
        end
        ACT_RELEASE: begin
          if (ok_r) begin
            out_data_r.partition_index_out <= item_r.partition_index;
            out_data_r.owner_out           <= OWN_F_W'(owner_r);
          end else begin
            out_data_r.status <= ST_BAD_INDEX;
          end
        end
        default: begin
          out_data_r.status <= ST_OK;
        end
      endcase
    end
  end

  // Checks
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted word did not start processing");

  a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && wr_en) |-> rd_addr != wr_addr)
    else $error("memory read and write hit the same entry");

  a_found_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    found_r |-> item_r.action == ACT_ALLOC)
    else $error("grant flag set outside allocate");

  a_proc_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    proc_vld_r |-> state_r == S_SCAN)
    else $error("memory entry processed outside the sweep");

endmodule
